>>> sv/i2cm_pkg.sv
// ----------------------------------------------------------------------------
// i2cm_pkg
// shared types, command codes and phase tables for the i2c bit engine
// ----------------------------------------------------------------------------
package i2cm_pkg;

  // width of the per-phase tick counter
  localparam int PHASE_COUNT_BITS = 16;
  // width of the phase_ticks register
  localparam int TICKS_W = 16;
  // compare width wide enough for both the register and the counter range
  localparam int LIM_W = ((PHASE_COUNT_BITS > TICKS_W) ? PHASE_COUNT_BITS : TICKS_W) + 1;
  localparam logic [TICKS_W-1:0] TICKS_RESET = 16'd1000;
  localparam int STEP_W = 5;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [2:0] {
    CMD_IDLE  = 3'd0,
    CMD_START = 3'd1,
    CMD_STOP  = 3'd2,
    CMD_SEND  = 3'd3,
    CMD_RECV  = 3'd4,
    CMD_RACK  = 3'd5,
    CMD_SACK  = 3'd6
  } cmd_t;

  // one classified tick as it sits in the queue
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] write_data;
    logic       ack_level;
    logic       sda_in;
  } tick_t;

  // number of pin phases for each command
  function automatic logic [STEP_W-1:0] phase_total(input cmd_t cmd);
    logic [STEP_W-1:0] n;
    case (cmd)
      CMD_START: n = 5'd4;
      CMD_STOP:  n = 5'd4;
      CMD_SEND:  n = 5'd24;
      CMD_RECV:  n = 5'd25;
      CMD_RACK:  n = 5'd4;
      CMD_SACK:  n = 5'd3;
      default:   n = 5'd0;
    endcase
    return n;
  endfunction

endpackage

>>> sv/i2cm_if.sv
// ----------------------------------------------------------------------------
// i2cm_if
// valid/ready channels of the i2c bit engine: tick in, pin status out
// ----------------------------------------------------------------------------
interface i2cm_tick_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [7:0] write_data;
  logic       ack_level;
  logic       sda_in;

  modport source (output valid, action, write_data, ack_level, sda_in, input ready);
  modport sink (input valid, action, write_data, ack_level, sda_in, output ready);
endinterface

interface i2cm_status_if;
  logic       valid;
  logic       ready;
  logic       scl_out;
  logic       sda_out;
  logic       busy_res;
  logic       done_res;
  logic [7:0] read_data;
  logic       ack_received;

  modport source (output valid, scl_out, sda_out, busy_res, done_res, read_data,
                  ack_received, input ready);
  modport sink (input valid, scl_out, sda_out, busy_res, done_res, read_data,
                ack_received, output ready);
endinterface

>>> sv/i2cm_front.sv
// ----------------------------------------------------------------------------
// i2cm_front
// accepts ticks and decodes the action field into a command
// ----------------------------------------------------------------------------
module i2cm_front (
  i2cm_tick_if.sink       tick,
  output logic            push_valid,
  input  logic            push_ready,
  output i2cm_pkg::tick_t push_data
);

  i2cm_pkg::cmd_t cmd;

  // unused code seven reads as no command
  always_comb begin
    case (tick.action)
      i2cm_pkg::CMD_START: cmd = i2cm_pkg::CMD_START;
      i2cm_pkg::CMD_STOP:  cmd = i2cm_pkg::CMD_STOP;
      i2cm_pkg::CMD_SEND:  cmd = i2cm_pkg::CMD_SEND;
      i2cm_pkg::CMD_RECV:  cmd = i2cm_pkg::CMD_RECV;
      i2cm_pkg::CMD_RACK:  cmd = i2cm_pkg::CMD_RACK;
      i2cm_pkg::CMD_SACK:  cmd = i2cm_pkg::CMD_SACK;
      default:             cmd = i2cm_pkg::CMD_IDLE;
    endcase
  end

  assign push_valid           = tick.valid;
  assign tick.ready           = push_ready;
  assign push_data.cmd        = cmd;
  assign push_data.write_data = tick.write_data;
  assign push_data.ack_level  = tick.ack_level;
  assign push_data.sda_in     = tick.sda_in;

endmodule

>>> sv/i2cm_queue.sv
// ----------------------------------------------------------------------------
// i2cm_queue
// two-entry fifo between the decode front and the sequencer
// ----------------------------------------------------------------------------
module i2cm_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            push_valid,
  output logic            push_ready,
  input  i2cm_pkg::tick_t push_data,
  output logic            pop_valid,
  input  logic            pop_ready,
  output i2cm_pkg::tick_t pop_data
);

  localparam int PTR_W = $clog2(i2cm_pkg::QUEUE_DEPTH);

  i2cm_pkg::tick_t mem [i2cm_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count != (PTR_W+1)'(i2cm_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

>>> sv/i2cm_back.sv
// ----------------------------------------------------------------------------
// i2cm_back
// pin phase sequencer with a registered status output
// ----------------------------------------------------------------------------
module i2cm_back (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [i2cm_pkg::TICKS_W-1:0]  phase_ticks,
  input  logic                          pop_valid,
  output logic                          pop_ready,
  input  i2cm_pkg::tick_t               pop_data,
  i2cm_status_if.source                 status
);

  localparam int PCB  = i2cm_pkg::PHASE_COUNT_BITS;
  localparam int LW   = i2cm_pkg::LIM_W;
  localparam int SW   = i2cm_pkg::STEP_W;

  // sequencer state
  i2cm_pkg::cmd_t cur;
  i2cm_pkg::cmd_t cur_next;
  logic [PCB-1:0] cnt;
  logic [PCB-1:0] cnt_next;
  logic [SW-1:0]  step;
  logic [SW-1:0]  step_next;
  logic [1:0]     sub;
  logic [1:0]     sub_next;
  logic [2:0]     bitx;
  logic [2:0]     bitx_next;
  logic           scl;
  logic           scl_next;
  logic           sda;
  logic           sda_next;
  logic [7:0]     shreg;
  logic [7:0]     shreg_next;
  logic           ackr;
  logic           ackr_next;
  logic [7:0]     tx;
  logic [7:0]     tx_next;
  logic           done_next;

  logic           adv;
  logic [LW-1:0]  lim;
  logic [LW-1:0]  cap;
  logic           phase_end;
  logic           run;
  i2cm_pkg::cmd_t run_cmd;
  logic [SW-1:0]  run_step;
  logic [7:0]     bit_mask;

  assign pop_ready = !status.valid || status.ready;
  assign adv       = pop_valid && pop_ready;

  // zero reads as one, and the length saturates to the counter range
  always_comb begin
    cap = LW'((64'd1 << PCB) - 64'd1);
    lim = (phase_ticks == '0) ? LW'(1) : LW'(phase_ticks);
    if (lim > cap) begin
      lim = cap;
    end
    phase_end = (LW'(cnt) + LW'(1)) >= lim;
  end

  always_comb begin
    cur_next   = cur;
    cnt_next   = cnt;
    step_next  = step;
    sub_next   = sub;
    bitx_next  = bitx;
    scl_next   = scl;
    sda_next   = sda;
    shreg_next = shreg;
    ackr_next  = ackr;
    tx_next    = tx;
    done_next  = 1'b0;
    run        = 1'b0;
    run_cmd    = cur;
    run_step   = step;
    bit_mask   = 8'h80;

    if (cur == i2cm_pkg::CMD_IDLE) begin
      if (pop_data.cmd != i2cm_pkg::CMD_IDLE) begin
        cur_next  = pop_data.cmd;
        step_next = '0;
        cnt_next  = '0;
        // receive byte starts one phase early so its bit counters wrap to zero
        if (pop_data.cmd == i2cm_pkg::CMD_RECV) begin
          sub_next   = 2'd2;
          bitx_next  = 3'd7;
          shreg_next = '0;
        end else begin
          sub_next  = 2'd0;
          bitx_next = 3'd0;
        end
        if (pop_data.cmd == i2cm_pkg::CMD_SEND) begin
          tx_next = pop_data.write_data;
        end else if (pop_data.cmd == i2cm_pkg::CMD_SACK) begin
          tx_next = {7'd0, pop_data.ack_level};
        end
        run      = 1'b1;
        run_cmd  = pop_data.cmd;
        run_step = '0;
      end
    end else if (phase_end) begin
      cnt_next  = '0;
      step_next = step + 1'b1;
      if (sub == 2'd2) begin
        sub_next  = 2'd0;
        bitx_next = bitx + 1'b1;
      end else begin
        sub_next = sub + 1'b1;
      end
      if (step_next >= i2cm_pkg::phase_total(cur)) begin
        cur_next  = i2cm_pkg::CMD_IDLE;
        step_next = '0;
        done_next = 1'b1;
      end else begin
        run      = 1'b1;
        run_step = step_next;
      end
    end else begin
      cnt_next = cnt + 1'b1;
    end

    bit_mask = 8'h80 >> bitx_next;

    // pin change or sample that opens the phase
    if (run) begin
      case (run_cmd)
        i2cm_pkg::CMD_START: begin
          case (run_step[1:0])
            2'd0:    scl_next = 1'b1;
            2'd1:    sda_next = 1'b1;
            2'd2:    sda_next = 1'b0;
            default: scl_next = 1'b0;
          endcase
        end
        i2cm_pkg::CMD_STOP: begin
          case (run_step[1:0])
            2'd0:    scl_next = 1'b0;
            2'd1:    sda_next = 1'b0;
            2'd2:    scl_next = 1'b1;
            default: sda_next = 1'b1;
          endcase
        end
        i2cm_pkg::CMD_SEND: begin
          case (sub_next)
            2'd0:    sda_next = |(tx_next & bit_mask);
            2'd1:    scl_next = 1'b1;
            default: scl_next = 1'b0;
          endcase
        end
        i2cm_pkg::CMD_RECV: begin
          if (run_step == '0) begin
            sda_next = 1'b1;
          end else begin
            case (sub_next)
              2'd0: scl_next = 1'b1;
              2'd1: begin
                if (pop_data.sda_in) begin
                  shreg_next = shreg_next | bit_mask;
                end
              end
              default: scl_next = 1'b0;
            endcase
          end
        end
        i2cm_pkg::CMD_RACK: begin
          case (run_step[1:0])
            2'd0:    sda_next  = 1'b1;
            2'd1:    scl_next  = 1'b1;
            2'd2:    ackr_next = pop_data.sda_in;
            default: scl_next  = 1'b0;
          endcase
        end
        i2cm_pkg::CMD_SACK: begin
          case (run_step[1:0])
            2'd0:    sda_next = tx_next[0];
            2'd1:    scl_next = 1'b1;
            default: scl_next = 1'b0;
          endcase
        end
        default: begin
          scl_next = scl;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur   <= i2cm_pkg::CMD_IDLE;
      cnt   <= '0;
      step  <= '0;
      sub   <= '0;
      bitx  <= '0;
      scl   <= 1'b1;
      sda   <= 1'b1;
      shreg <= '0;
      ackr  <= 1'b1;
      tx    <= '0;
    end else if (adv) begin
      cur   <= cur_next;
      cnt   <= cnt_next;
      step  <= step_next;
      sub   <= sub_next;
      bitx  <= bitx_next;
      scl   <= scl_next;
      sda   <= sda_next;
      shreg <= shreg_next;
      ackr  <= ackr_next;
      tx    <= tx_next;
    end
  end

  // status register
  always_ff @(posedge clk) begin
    if (rst) begin
      status.valid <= 1'b0;
    end else if (pop_ready) begin
      status.valid <= pop_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status.scl_out      <= scl_next;
      status.sda_out      <= sda_next;
      status.busy_res     <= (cur_next != i2cm_pkg::CMD_IDLE);
      status.done_res     <= done_next;
      status.read_data    <= shreg_next;
      status.ack_received <= ackr_next;
    end
  end

  a_idle_step_zero: assert property (@(posedge clk) disable iff (rst)
    (cur == i2cm_pkg::CMD_IDLE) |-> (step == '0))
    else $error("step index not cleared while idle");

  a_step_in_range: assert property (@(posedge clk) disable iff (rst)
    (cur != i2cm_pkg::CMD_IDLE) |-> (step < i2cm_pkg::phase_total(cur)))
    else $error("step index past end of command");

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    (status.valid && status.done_res) |-> !status.busy_res)
    else $error("done with busy still set");

  a_cmd_starts: assert property (@(posedge clk) disable iff (rst)
    (adv && cur == i2cm_pkg::CMD_IDLE && pop_data.cmd != i2cm_pkg::CMD_IDLE)
      |=> (cur != i2cm_pkg::CMD_IDLE))
    else $error("accepted command did not start");

endmodule

>>> sv/i2c_master_bit_engine.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// bit-level i2c master: start, stop, byte and ack phases timed in ticks
// ----------------------------------------------------------------------------
//  channel   dir  handshake     contents
//  tick      in   valid/ready   action, write_data, ack_level, sda_in
//  status    out  valid/ready   scl_out, sda_out, busy_res, done_res,
//                               read_data, ack_received
//  cfg       in   cfg_we        phase_ticks (cfg_data)
//
//  one tick item is taken per cycle while the queue has room, and yields one status item
//  (decode into the queue, then the sequencer step into the status register)
//  throughput is set by the sequencer, which retires one queued tick each cycle while
//  the status output is not stalled; a stalled status output holds the sequencer and
//  the two-entry queue keeps the tick side taking items until it fills
//  rst is synchronous: pins released high, sequencer idle, phase_ticks 1000
// ----------------------------------------------------------------------------
module i2c_master_bit_engine (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic [i2cm_pkg::TICKS_W-1:0] cfg_data,
  i2cm_tick_if.sink                    tick,
  i2cm_status_if.source                status
);

  // phase length register
  logic [i2cm_pkg::TICKS_W-1:0] phase_ticks;

  // front to queue
  logic            push_valid;
  logic            push_ready;
  i2cm_pkg::tick_t push_data;

  // queue to sequencer
  logic            pop_valid;
  logic            pop_ready;
  i2cm_pkg::tick_t pop_data;

  // the user must write only with the queue drained, so writes land between items; the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_ticks <= i2cm_pkg::TICKS_RESET;
    end else if (cfg_we) begin
      phase_ticks <= cfg_data;
    end
  end

  // decode the action code of each tick
  i2cm_front u_front (
    .tick       (tick),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  // decouples tick acceptance from status backpressure
  i2cm_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // phase sequencer and status register
  i2cm_back u_back (
    .clk         (clk),
    .rst         (rst),
    .phase_ticks (phase_ticks),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .status      (status)
  );

endmodule
